@@ src/grid_overlay_pixel_blend_assert.svh @@
// ----------------------------------------------------------------------------
// grid overlay assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off while rst_ni low.
// ----------------------------------------------------------------------------
`ifndef GRID_OVERLAY_PIXEL_BLEND_ASSERT_SVH
`define GRID_OVERLAY_PIXEL_BLEND_ASSERT_SVH

// condition must hold whenever the antecedent holds
`define GOP_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gop assertion failed");

// condition must hold on every clock
`define GOP_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("gop assertion failed");

`endif

@@ src/gop_pkg.sv @@
// ----------------------------------------------------------------------------
// gop_pkg
// Constants, types and arithmetic helpers of the grid overlay pixel blend.
// ----------------------------------------------------------------------------
package gop_pkg;

  localparam int CELL_SIZE   = 48;
  localparam int COORD_W     = 13;
  localparam int PIXEL_W     = 32;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_IDX_W   = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OPACITY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 2'd3;

  localparam logic [7:0] OPACITY_RESET = 8'd13;
  localparam logic [7:0] ALPHA_MAX     = 8'hFF;

  // reciprocal division by the cell size, exact for any dividend below 2**DIVD_W
  localparam int DIVD_W   = COORD_W + 1;
  localparam int DIV_SH   = DIVD_W + $clog2(CELL_SIZE);
  localparam int RECIP_W  = DIVD_W + 1;
  localparam int PROD_W   = DIVD_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((2 ** DIV_SH) + CELL_SIZE - 1) / CELL_SIZE);
  localparam int CELL_Q_W = $clog2(((2 ** DIVD_W) - 1) / CELL_SIZE + 1);

  localparam int NUM_BLEND  = 3;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int FRONT_STAGES = 2;
  localparam int PIPE_CAP   = FRONT_STAGES + FIFO_DEPTH + NUM_BLEND;
  localparam int FLIGHT_W   = $clog2(PIPE_CAP + 1);

  typedef struct packed {
    logic                  enable;
    logic [7:0]            opacity;
    logic [COORD_W-1:0]    width;
    logic [COORD_W-1:0]    height;
  } cfg_t;

  // classified pixel: flag bit k selects blend stage k
  typedef struct packed {
    logic [PIXEL_W-1:0]    pixel;
    logic [NUM_BLEND-1:0]  flags;
  } cls_t;

  function automatic logic [CELL_Q_W-1:0] div_cell(input logic [DIVD_W-1:0] n);
    logic [PROD_W-1:0] p;
    p = PROD_W'(n) * PROD_W'(RECIP);
    return p[DIV_SH +: CELL_Q_W];
  endfunction

  function automatic logic [DIVD_W-1:0] cell_base(input logic [CELL_Q_W-1:0] q);
    return DIVD_W'(DIVD_W'(q) * DIVD_W'(CELL_SIZE));
  endfunction

  // white over c at alpha a: (255*a + c*(255-a)) / 255, truncated
  function automatic logic [7:0] blend_chan(input logic [7:0] c, input logic [7:0] a);
    logic [15:0] n;
    logic [16:0] t;
    n = 16'(16'(a) * 16'd255) + 16'(16'(c) * 16'(8'd255 - a));
    t = 17'(n) + 17'(n[15:8]) + 17'd1;
    return t[15:8];
  endfunction

  function automatic logic [PIXEL_W-1:0] blend_white(input logic [PIXEL_W-1:0] px,
                                                     input logic [7:0] a);
    return {ALPHA_MAX, blend_chan(px[23:16], a), blend_chan(px[15:8], a),
            blend_chan(px[7:0], a)};
  endfunction

endpackage

@@ src/gop_intf.sv @@
// ----------------------------------------------------------------------------
// gop interfaces
// Valid/ready channels for incoming pixels and blended results.
// ----------------------------------------------------------------------------
interface gop_pix_if;
  logic                            valid;
  logic                            ready;
  logic [gop_pkg::COORD_W-1:0]     pixel_x;
  logic [gop_pkg::COORD_W-1:0]     pixel_y;
  logic [gop_pkg::PIXEL_W-1:0]     background_pixel;

  modport source (output valid, pixel_x, pixel_y, background_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, background_pixel, output ready);
endinterface

interface gop_res_if;
  logic                            valid;
  logic                            ready;
  logic [gop_pkg::PIXEL_W-1:0]     result_pixel;
  logic                            touched;

  modport source (output valid, result_pixel, touched, input ready);
  modport sink   (input valid, result_pixel, touched, output ready);
endinterface

@@ src/grid_overlay_pixel_blend.sv @@
// ----------------------------------------------------------------------------
// grid_overlay_pixel_blend
// Blends a white cell grid with node marks over a stream of pixels.
// ----------------------------------------------------------------------------
//  channel   dir  fields
//  pix_i     in   pixel_x[12:0], pixel_y[12:0], background_pixel[31:0]
//  res_o     out  result_pixel[31:0], touched
//  cfg       in   cfg_we_i, cfg_idx_i[1:0], cfg_data_i[12:0]
//
// One pixel per clock sustained while res_o is ready; a result passes six
// register stages (two classifier, one queue slot, three blend; the first
// one loads on the transaction edge).
// Each blend stage holds one set of 8x8 channel multipliers per color.
// Reset clears control state and loads register defaults; no memory sweep.
// A stalled res_o fills the blend pipe, then the two-entry queue, then the
// classifier, and only then drops pix_i.ready.
// ----------------------------------------------------------------------------
`include "grid_overlay_pixel_blend_assert.svh"

module grid_overlay_pixel_blend (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [gop_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [gop_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  gop_pix_if.sink                            pix_i,
  gop_res_if.source                          res_o
);

  gop_pkg::cfg_t  cfg_q;
  logic           fq_valid, fq_ready, bq_valid, bq_ready;
  gop_pkg::cls_t  fq_data, bq_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable  <= 1'b1;
      cfg_q.opacity <= gop_pkg::OPACITY_RESET;
      cfg_q.width   <= '0;
      cfg_q.height  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gop_pkg::REG_ENABLE:  cfg_q.enable  <= cfg_data_i[0];
        gop_pkg::REG_OPACITY: cfg_q.opacity <= cfg_data_i[7:0];
        gop_pkg::REG_WIDTH:   cfg_q.width   <= cfg_data_i[gop_pkg::COORD_W-1:0];
        gop_pkg::REG_HEIGHT:  cfg_q.height  <= cfg_data_i[gop_pkg::COORD_W-1:0];
        default:              cfg_q         <= cfg_q;
      endcase
    end
  end

  gop_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pix_i       (pix_i),
    .cls_valid_o (fq_valid),
    .cls_ready_i (fq_ready),
    .cls_data_o  (fq_data)
  );

  gop_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fq_valid),
    .wr_ready_o (fq_ready),
    .wr_data_i  (fq_data),
    .rd_valid_o (bq_valid),
    .rd_ready_i (bq_ready),
    .rd_data_o  (bq_data)
  );

  gop_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cls_valid_i (bq_valid),
    .cls_ready_o (bq_ready),
    .cls_data_i  (bq_data),
    .res_o       (res_o)
  );

  // transactions in flight, for checking only
  logic [gop_pkg::FLIGHT_W-1:0] flight_q;
  logic                         in_acc, out_acc;

  assign in_acc  = pix_i.valid && pix_i.ready;
  assign out_acc = res_o.valid && res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flight_q <= '0;
    end else if (in_acc && !out_acc) begin
      flight_q <= flight_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      flight_q <= flight_q - 1'b1;
    end
  end

  `GOP_ASSERT_IMPLY(a_touched_alpha, res_o.valid && res_o.touched, res_o.result_pixel[31:24] == gop_pkg::ALPHA_MAX)
  `GOP_ASSERT_ALWAYS(a_flight_cap, flight_q <= gop_pkg::FLIGHT_W'(gop_pkg::PIPE_CAP))
  `GOP_ASSERT_IMPLY(a_no_phantom, res_o.valid, flight_q != '0)

endmodule

@@ src/gop_front.sv @@
// ----------------------------------------------------------------------------
// gop_front
// Two-stage classifier: finds the cell grid position of a pixel and decides
// which of the line and node blends apply.
// ----------------------------------------------------------------------------
module gop_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gop_pkg::cfg_t       cfg_i,
  gop_pix_if.sink             pix_i,
  output logic                cls_valid_o,
  input  logic                cls_ready_i,
  output gop_pkg::cls_t       cls_data_o
);

  // stage a: quotients
  logic                              a_valid_q;
  logic                              a_act_q;
  logic [gop_pkg::COORD_W-1:0]       a_x_q, a_y_q;
  logic [gop_pkg::PIXEL_W-1:0]       a_px_q;
  logic [gop_pkg::CELL_Q_W-1:0]      a_col_q, a_row_q, a_ncol_q, a_nrow_q;
  logic [gop_pkg::CELL_Q_W-1:0]      a_cols_q, a_rows_q;
  logic                              a_ready;
  logic                              act;

  // stage b: classified pixel
  logic                              b_valid_q;
  gop_pkg::cls_t                     b_data_q;
  logic                              b_ready;

  assign b_ready     = !b_valid_q || cls_ready_i;
  assign a_ready     = !a_valid_q || b_ready;
  assign pix_i.ready = a_ready;

  assign act = cfg_i.enable && (cfg_i.opacity != 8'd0) &&
               (pix_i.pixel_x < cfg_i.width) && (pix_i.pixel_y < cfg_i.height);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && pix_i.valid) begin
      a_act_q  <= act;
      a_x_q    <= pix_i.pixel_x;
      a_y_q    <= pix_i.pixel_y;
      a_px_q   <= pix_i.background_pixel;
      a_col_q  <= gop_pkg::div_cell(gop_pkg::DIVD_W'(pix_i.pixel_x));
      a_row_q  <= gop_pkg::div_cell(gop_pkg::DIVD_W'(pix_i.pixel_y));
      // nearest intersection lies at most two pixels ahead
      a_ncol_q <= gop_pkg::div_cell(gop_pkg::DIVD_W'(pix_i.pixel_x) + gop_pkg::DIVD_W'(2));
      a_nrow_q <= gop_pkg::div_cell(gop_pkg::DIVD_W'(pix_i.pixel_y) + gop_pkg::DIVD_W'(2));
      a_cols_q <= gop_pkg::div_cell(gop_pkg::DIVD_W'(cfg_i.width));
      a_rows_q <= gop_pkg::div_cell(gop_pkg::DIVD_W'(cfg_i.height));
    end
  end

  logic                          hline, vline, node, node_in, ce, re;
  logic signed [gop_pkg::DIVD_W:0] dx, dy;
  logic [gop_pkg::DIVD_W:0]      adx, ady;
  logic [gop_pkg::DIVD_W+1:0]    md;

  always_comb begin
    hline = a_act_q && (gop_pkg::cell_base(a_row_q) == gop_pkg::DIVD_W'(a_y_q)) &&
            (a_row_q != '0) && (a_row_q < a_rows_q);
    vline = a_act_q && (gop_pkg::cell_base(a_col_q) == gop_pkg::DIVD_W'(a_x_q)) &&
            (a_col_q != '0) && (a_col_q < a_cols_q);
    dx = $signed({2'b00, a_x_q}) - $signed({1'b0, gop_pkg::cell_base(a_ncol_q)});
    dy = $signed({2'b00, a_y_q}) - $signed({1'b0, gop_pkg::cell_base(a_nrow_q)});
    adx = dx[gop_pkg::DIVD_W] ? (gop_pkg::DIVD_W+1)'(-dx) : (gop_pkg::DIVD_W+1)'(dx);
    ady = dy[gop_pkg::DIVD_W] ? (gop_pkg::DIVD_W+1)'(-dy) : (gop_pkg::DIVD_W+1)'(dy);
    md  = (gop_pkg::DIVD_W+2)'(adx) + (gop_pkg::DIVD_W+2)'(ady);
    ce  = !a_ncol_q[0];
    re  = !a_nrow_q[0];
    node_in = a_act_q && (a_ncol_q != '0) && (a_ncol_q < a_cols_q) &&
              (a_nrow_q != '0) && (a_nrow_q < a_rows_q);
    // diamond on even-even nodes, cross on odd-odd nodes
    node = node_in && ((ce && re && (md == (gop_pkg::DIVD_W+2)'(2))) ||
                       (!ce && !re && (md <= (gop_pkg::DIVD_W+2)'(1))));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && a_valid_q) begin
      b_data_q.pixel <= a_px_q;
      b_data_q.flags <= {node, vline, hline};
    end
  end

  assign cls_valid_o = b_valid_q;
  assign cls_data_o  = b_data_q;

endmodule

@@ src/gop_fifo.sv @@
// ----------------------------------------------------------------------------
// gop_fifo
// Short queue of classified pixels between the classifier and blend pipe.
// ----------------------------------------------------------------------------
module gop_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  output logic            wr_ready_o,
  input  gop_pkg::cls_t   wr_data_i,
  output logic            rd_valid_o,
  input  logic            rd_ready_i,
  output gop_pkg::cls_t   rd_data_o
);

  gop_pkg::cls_t                   mem_q [gop_pkg::FIFO_DEPTH];
  logic [gop_pkg::FIFO_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [gop_pkg::FIFO_CNT_W-1:0]  cnt_q;
  logic                            push, pop;

  assign wr_ready_o = (cnt_q != gop_pkg::FIFO_CNT_W'(gop_pkg::FIFO_DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

@@ src/gop_back.sv @@
// ----------------------------------------------------------------------------
// gop_back
// Blend pipe: horizontal line, vertical line and node blends, one stage each;
// the last stage is the output register.
// ----------------------------------------------------------------------------
module gop_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  gop_pkg::cfg_t   cfg_i,
  input  logic            cls_valid_i,
  output logic            cls_ready_o,
  input  gop_pkg::cls_t   cls_data_i,
  gop_res_if.source       res_o
);

  localparam int NB = gop_pkg::NUM_BLEND;

  logic [NB-1:0]                v_q;
  logic [gop_pkg::PIXEL_W-1:0]  px_q [NB];
  logic [NB-1:0]                fl_q [NB];
  logic [NB-1:0]                t_q;
  logic [NB:0]                  rdy;
  logic [7:0]                   line_a, node_a;

  assign line_a = cfg_i.opacity;
  assign node_a = cfg_i.opacity[7] ? gop_pkg::ALPHA_MAX : {cfg_i.opacity[6:0], 1'b0};

  assign rdy[NB]     = res_o.ready;
  assign cls_ready_o = rdy[0];

  for (genvar k = 0; k < NB; k++) begin : g_stage
    logic                          in_v;
    logic [gop_pkg::PIXEL_W-1:0]   in_px;
    logic [NB-1:0]                 in_fl;
    logic                          in_t;
    logic [7:0]                    alpha;

    if (k == 0) begin : g_head
      assign in_v  = cls_valid_i;
      assign in_px = cls_data_i.pixel;
      assign in_fl = cls_data_i.flags;
      assign in_t  = 1'b0;
    end else begin : g_link
      assign in_v  = v_q[k-1];
      assign in_px = px_q[k-1];
      assign in_fl = fl_q[k-1];
      assign in_t  = t_q[k-1];
    end

    // the node blend comes last and uses the doubled alpha
    assign alpha  = (k == NB - 1) ? node_a : line_a;
    assign rdy[k] = !v_q[k] || rdy[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= in_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && in_v) begin
        px_q[k] <= in_fl[k] ? gop_pkg::blend_white(in_px, alpha) : in_px;
        fl_q[k] <= in_fl;
        t_q[k]  <= in_t || in_fl[k];
      end
    end
  end

  assign res_o.valid        = v_q[NB-1];
  assign res_o.result_pixel = px_q[NB-1];
  assign res_o.touched      = t_q[NB-1];

endmodule

@@ bench/grid_overlay_pixel_blend_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_overlay_pixel_blend_tb
// Streams pixels through the grid overlay under a series of register
// settings and checks every result against an expected value from the
// table or an in-bench predictor. A short table covers grid lines, nodes
// and pass-through cases, then random phases follow. Bursty input and a
// stalling output exercise the handshake.
module grid_overlay_pixel_blend_tb;

  localparam int COORD_MAX       = 2 ** gop_pkg::COORD_W - 1;
  localparam int SETTLE_CYCLES   = 10;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 60;
  localparam int HOLD_AT         = 300;
  localparam int HOLD_CYCLES     = 64;
  localparam int STALL_LIMIT     = 1000;

  typedef enum logic {ROW_WRITE, ROW_PIXEL} row_kind_e;
  typedef enum logic [1:0] {RX_OPEN, RX_HALF, RX_MOSTLY, RX_SPARSE} rx_mode_e;

  typedef struct packed {
    logic [gop_pkg::PIXEL_W-1:0] pixel;
    logic                        touched;
  } overlay_t;

  typedef struct {
    row_kind_e                      kind;
    logic [gop_pkg::CFG_IDX_W-1:0]  idx;
    logic [gop_pkg::CFG_DATA_W-1:0] data;
    logic [gop_pkg::COORD_W-1:0]    x;
    logic [gop_pkg::COORD_W-1:0]    y;
    logic [gop_pkg::PIXEL_W-1:0]    bg;
    bit                             known;
    overlay_t                       want;
  } row_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we;
  logic [gop_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [gop_pkg::CFG_DATA_W-1:0] cfg_data;

  gop_pix_if pix ();
  gop_res_if res ();

  grid_overlay_pixel_blend uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix_i      (pix),
    .res_o      (res)
  );

  gop_pkg::cfg_t grid_cfg;
  overlay_t      expected_pixels[$];
  row_t          directed[$];
  overlay_t      oldest;
  int            errors;
  int            pixels_sent;
  int            burst_left;
  int            idle_cycles;
  bit            hold_done;
  rx_mode_e      rx_mode;
  int            rx_left;

  always #5 clk_i = ~clk_i;

  // white over one channel at alpha a, truncated
  function automatic logic [7:0] whiten(input logic [7:0] c, input logic [7:0] a);
    int unsigned v;
    v = (255 * a + c * (255 - a)) / 255;
    return v[7:0];
  endfunction

  function automatic logic [gop_pkg::PIXEL_W-1:0] whiten_pixel(
      input logic [gop_pkg::PIXEL_W-1:0] px, input logic [7:0] a);
    return {gop_pkg::ALPHA_MAX, whiten(px[23:16], a), whiten(px[15:8], a),
            whiten(px[7:0], a)};
  endfunction

  function automatic overlay_t predict_overlay(input gop_pkg::cfg_t c,
                                               input logic [gop_pkg::COORD_W-1:0] x,
                                               input logic [gop_pkg::COORD_W-1:0] y,
                                               input logic [gop_pkg::PIXEL_W-1:0] bg);
    int xi, yi, cols, rows, ncol, nrow, dx, dy, md, node_a;
    overlay_t r;
    r.pixel   = bg;
    r.touched = 1'b0;
    xi = int'(x);
    yi = int'(y);
    if (c.enable && c.opacity != 0 && xi < int'(c.width) && yi < int'(c.height)) begin
      cols   = int'(c.width) / gop_pkg::CELL_SIZE;
      rows   = int'(c.height) / gop_pkg::CELL_SIZE;
      node_a = (2 * int'(c.opacity) > 255) ? 255 : 2 * int'(c.opacity);
      // nearest intersection, reached from up to two pixels before it
      ncol = (xi + 2) / gop_pkg::CELL_SIZE;
      nrow = (yi + 2) / gop_pkg::CELL_SIZE;
      dx   = xi - ncol * gop_pkg::CELL_SIZE;
      dy   = yi - nrow * gop_pkg::CELL_SIZE;
      if (yi % gop_pkg::CELL_SIZE == 0 && yi / gop_pkg::CELL_SIZE > 0 &&
          yi / gop_pkg::CELL_SIZE < rows) begin
        r.pixel   = whiten_pixel(r.pixel, c.opacity);
        r.touched = 1'b1;
      end
      if (xi % gop_pkg::CELL_SIZE == 0 && xi / gop_pkg::CELL_SIZE > 0 &&
          xi / gop_pkg::CELL_SIZE < cols) begin
        r.pixel   = whiten_pixel(r.pixel, c.opacity);
        r.touched = 1'b1;
      end
      if (ncol > 0 && ncol < cols && nrow > 0 && nrow < rows) begin
        md = (dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy);
        // diamond on even-even, cross on odd-odd, nothing on mixed parity
        if ((ncol % 2 == 0 && nrow % 2 == 0 && md == 2) ||
            (ncol % 2 == 1 && nrow % 2 == 1 && md <= 1)) begin
          r.pixel   = whiten_pixel(r.pixel, node_a[7:0]);
          r.touched = 1'b1;
        end
      end
    end
    return r;
  endfunction

  function automatic row_t wr(input logic [gop_pkg::CFG_IDX_W-1:0] idx, input int value);
    row_t r;
    r       = '{kind: ROW_WRITE, default: '0};
    r.kind  = ROW_WRITE;
    r.idx   = idx;
    r.data  = value[gop_pkg::CFG_DATA_W-1:0];
    return r;
  endfunction

  function automatic row_t px_row(input int x, input int y,
                                  input logic [gop_pkg::PIXEL_W-1:0] bg);
    row_t r;
    r      = '{kind: ROW_PIXEL, default: '0};
    r.kind = ROW_PIXEL;
    r.x    = x[gop_pkg::COORD_W-1:0];
    r.y    = y[gop_pkg::COORD_W-1:0];
    r.bg   = bg;
    return r;
  endfunction

  function automatic row_t known_row(input int x, input int y,
                                     input logic [gop_pkg::PIXEL_W-1:0] bg,
                                     input logic [gop_pkg::PIXEL_W-1:0] want_px,
                                     input logic want_t);
    row_t r;
    r              = px_row(x, y, bg);
    r.known        = 1'b1;
    r.want.pixel   = want_px;
    r.want.touched = want_t;
    return r;
  endfunction

  // half near grid lines and nodes, some anywhere in frame, some anywhere at all
  function automatic int pick_coord(input int span);
    int unsigned sel;
    int k, off, v;
    sel = $urandom_range(0, 9);
    if (sel < 5) begin
      k   = $urandom_range(0, span / gop_pkg::CELL_SIZE + 1);
      off = $urandom_range(0, 6);
      v   = k * gop_pkg::CELL_SIZE + off - 3;
    end else if (sel < 8 && span > 0) begin
      v = $urandom_range(0, span - 1);
    end else begin
      v = $urandom_range(0, COORD_MAX);
    end
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return v;
  endfunction

  function automatic logic [gop_pkg::PIXEL_W-1:0] pick_bg();
    int unsigned sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return $urandom;
  endfunction

  function automatic gop_pkg::cfg_t phase_cfg(input int n);
    gop_pkg::cfg_t c;
    c.enable  = 1'b1;
    c.opacity = 8'($urandom_range(1, 255));
    c.width   = gop_pkg::COORD_W'($urandom_range(0, COORD_MAX));
    c.height  = gop_pkg::COORD_W'($urandom_range(0, COORD_MAX));
    case (n)
      0: begin
        c.opacity = 8'd255;
        c.width   = gop_pkg::COORD_W'(COORD_MAX);
        c.height  = gop_pkg::COORD_W'(COORD_MAX);
      end
      1: begin
        c.opacity = 8'd1;
        c.width   = gop_pkg::COORD_W'(480);
        c.height  = gop_pkg::COORD_W'(384);
      end
      2: begin
        c.opacity = 8'd128;
        c.width   = gop_pkg::COORD_W'($urandom_range(96, 2000));
        c.height  = gop_pkg::COORD_W'($urandom_range(96, 2000));
      end
      3: c.enable = 1'b0;
      4: begin
        c.opacity = 8'd127;
        c.width   = gop_pkg::COORD_W'(2 * gop_pkg::CELL_SIZE - 1);
        c.height  = gop_pkg::COORD_W'(COORD_MAX);
      end
      5: c.height = gop_pkg::COORD_W'(2 * gop_pkg::CELL_SIZE);
      6: begin
        c.opacity = 8'd0;
        c.width   = '0;
        c.height  = gop_pkg::COORD_W'(COORD_MAX);
      end
      7: begin
        c.width  = gop_pkg::COORD_W'(COORD_MAX);
        c.height = gop_pkg::COORD_W'($urandom_range(0, 2 * gop_pkg::CELL_SIZE - 1));
      end
      default: begin
        c.enable  = ($urandom_range(0, 7) != 0);
        c.opacity = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 1) == 0) begin
          c.width  = gop_pkg::COORD_W'($urandom_range(96, 1000));
          c.height = gop_pkg::COORD_W'($urandom_range(96, 1000));
        end
      end
    endcase
    return c;
  endfunction

  task automatic write_reg(input logic [gop_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gop_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      gop_pkg::REG_ENABLE:  grid_cfg.enable  = value[0];
      gop_pkg::REG_OPACITY: grid_cfg.opacity = value[7:0];
      gop_pkg::REG_WIDTH:   grid_cfg.width   = value;
      gop_pkg::REG_HEIGHT:  grid_cfg.height  = value;
    endcase
  endtask

  task automatic wait_idle();
    pix.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_pixel(input row_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        pix.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    pix.valid            <= 1'b1;
    pix.pixel_x          <= r.x;
    pix.pixel_y          <= r.y;
    pix.background_pixel <= r.bg;
    do @(posedge clk_i); while (pix.ready !== 1'b1);
    burst_left--;
    pixels_sent++;
    expected_pixels.push_back(r.known ? r.want
                                      : predict_overlay(grid_cfg, r.x, r.y, r.bg));
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && res.valid === 1'b1 && res.ready === 1'b1) begin
      if (expected_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected result expected none got %08h touched %0b",
                 $time, res.result_pixel, res.touched);
      end else begin
        oldest = expected_pixels.pop_front();
        if (res.result_pixel !== oldest.pixel) begin
          errors++;
          $display("%0t: result_pixel expected %08h got %08h",
                   $time, oldest.pixel, res.result_pixel);
        end
        if (res.touched !== oldest.touched) begin
          errors++;
          $display("%0t: touched expected %0b got %0b", $time, oldest.touched, res.touched);
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if (pix.valid === 1'b1 && pix.ready === 1'b1 || res.valid === 1'b1 && res.ready === 1'b1) begin
      idle_cycles = 0;
    end else if (rst_ni) begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // output back-pressure
  initial begin
    res.ready = 1'b0;
    rx_mode   = RX_OPEN;
    rx_left   = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      // one long hold-off so the pipe and queue fill and the input stalls
      if (!hold_done && pixels_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        res.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(20, 120);
      end
      rx_left--;
      case (rx_mode)
        RX_OPEN:   res.ready <= 1'b1;
        RX_HALF:   res.ready <= ($urandom_range(0, 1) == 0);
        RX_MOSTLY: res.ready <= ($urandom_range(0, 7) != 0);
        RX_SPARSE: res.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin
    gop_pkg::cfg_t c;
    clk_i                = 1'b0;
    rst_ni               = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = gop_pkg::REG_ENABLE;
    cfg_data             = '0;
    pix.valid            = 1'b0;
    pix.pixel_x          = '0;
    pix.pixel_y          = '0;
    pix.background_pixel = '0;
    errors               = 0;
    pixels_sent          = 0;
    burst_left           = 0;
    idle_cycles          = 0;
    grid_cfg.enable      = 1'b1;
    grid_cfg.opacity     = gop_pkg::OPACITY_RESET;
    grid_cfg.width       = '0;
    grid_cfg.height      = '0;

    // reset frame is empty: everything passes
    directed.push_back(known_row(0, 0, 32'h12345678, 32'h12345678, 1'b0));
    directed.push_back(known_row(COORD_MAX, COORD_MAX, '1, '1, 1'b0));
    // 10 x 8 cells, full opacity: any blend saturates to white
    directed.push_back(wr(gop_pkg::REG_WIDTH, 480));
    directed.push_back(wr(gop_pkg::REG_HEIGHT, 384));
    directed.push_back(wr(gop_pkg::REG_OPACITY, 255));
    directed.push_back(known_row(48, 10, 32'h00000000, 32'hFFFFFFFF, 1'b1));
    directed.push_back(known_row(10, 96, 32'h00123456, 32'hFFFFFFFF, 1'b1));
    directed.push_back(known_row(0, 0, 32'h00ABCDEF, 32'h00ABCDEF, 1'b0));
    directed.push_back(known_row(97, 97, 32'h00000000, 32'hFFFFFFFF, 1'b1));
    directed.push_back(known_row(95, 95, 32'h7F000000, 32'hFFFFFFFF, 1'b1));
    directed.push_back(known_row(49, 49, 32'h00102030, 32'h00102030, 1'b0));
    directed.push_back(known_row(97, 49, 32'h00405060, 32'h00405060, 1'b0));
    directed.push_back(known_row(432, 10, 32'h00000000, 32'hFFFFFFFF, 1'b1));
    directed.push_back(known_row(480, 96, 32'h00010203, 32'h00010203, 1'b0));
    directed.push_back(known_row(96, 384, 32'h00010203, 32'h00010203, 1'b0));
    directed.push_back(known_row(478, 98, 32'h00AAAAAA, 32'h00AAAAAA, 1'b0));
    directed.push_back(px_row(48, 48, 32'h00000000));
    // weak lines, node alpha doubled
    directed.push_back(wr(gop_pkg::REG_OPACITY, 1));
    directed.push_back(px_row(96, 96, 32'h80808080));
    directed.push_back(px_row(49, 48, 32'h00000000));
    directed.push_back(px_row(48, 48, 32'h00FFFFFF));
    // node alpha saturates just above half scale
    directed.push_back(wr(gop_pkg::REG_OPACITY, 128));
    directed.push_back(px_row(97, 97, 32'h00123456));
    directed.push_back(wr(gop_pkg::REG_OPACITY, 127));
    directed.push_back(px_row(95, 95, 32'h00C0FFEE));
    directed.push_back(wr(gop_pkg::REG_ENABLE, 0));
    directed.push_back(known_row(48, 10, 32'h00000000, 32'h00000000, 1'b0));
    directed.push_back(known_row(97, 97, 32'h5A5A5A5A, 32'h5A5A5A5A, 1'b0));
    directed.push_back(wr(gop_pkg::REG_ENABLE, 1));
    directed.push_back(wr(gop_pkg::REG_OPACITY, 0));
    directed.push_back(known_row(48, 48, 32'h00000000, 32'h00000000, 1'b0));
    // narrow frame: one column, no vertical lines and no nodes
    directed.push_back(wr(gop_pkg::REG_OPACITY, 255));
    directed.push_back(wr(gop_pkg::REG_WIDTH, 2 * gop_pkg::CELL_SIZE - 1));
    directed.push_back(known_row(48, 10, 32'h00000000, 32'h00000000, 1'b0));
    directed.push_back(known_row(49, 97, 32'h00336699, 32'h00336699, 1'b0));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(directed[i].idx, directed[i].data);
      end else begin
        send_pixel(directed[i]);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      c = phase_cfg(p);
      write_reg(gop_pkg::REG_ENABLE, gop_pkg::CFG_DATA_W'(c.enable));
      write_reg(gop_pkg::REG_OPACITY, gop_pkg::CFG_DATA_W'(c.opacity));
      write_reg(gop_pkg::REG_WIDTH, c.width);
      write_reg(gop_pkg::REG_HEIGHT, c.height);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_pixel(px_row(pick_coord(int'(c.width)), pick_coord(int'(c.height)), pick_bg()));
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
